// File: design/lpr_pkg.sv
// Shared types and constants for the line pixel rasterizer.
`timescale 1ns / 1ps

package lpr_pkg;

    localparam int PORT_COORD_W = 8;
    localparam int COLOR_W      = 12;
    localparam int S_TDATA_W    = 48;
    localparam int M_TDATA_W    = 32;

    localparam logic OP_START = 1'b0;
    localparam logic OP_STEP  = 1'b1;

    typedef struct packed {
        logic                    op;
        logic [PORT_COORD_W-1:0] start_row;
        logic [PORT_COORD_W-1:0] start_col;
        logic [PORT_COORD_W-1:0] end_row;
        logic [PORT_COORD_W-1:0] end_col;
        logic [COLOR_W-1:0]      pen_color;
    } lpr_item_t;

    typedef struct packed {
        logic                    pixel_valid;
        logic [PORT_COORD_W-1:0] pixel_row;
        logic [PORT_COORD_W-1:0] pixel_col;
        logic [COLOR_W-1:0]      pixel_color;
        logic                    line_done;
    } lpr_result_t;

endpackage

// File: design/lpr_core.sv
// Line state registers and the per-item start and step logic.
`timescale 1ns / 1ps

module lpr_core
    import lpr_pkg::*;
#(
    parameter int COORD_BITS = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        item_fire,
    input  lpr_item_t   item,
    output lpr_result_t result
);

    localparam int C = COORD_BITS;
    localparam int D = COORD_BITS + 1;
    localparam int E = COORD_BITS + 3;

    logic [C-1:0]       row_now_reg, row_now_next;
    logic [C-1:0]       col_now_reg, col_now_next;
    logic [C-1:0]       row_goal_reg, row_goal_next;
    logic [C-1:0]       col_goal_reg, col_goal_next;
    logic               row_dir_neg_reg, row_dir_neg_next;
    logic               col_dir_neg_reg, col_dir_neg_next;
    logic [D-1:0]       twice_drow_reg, twice_drow_next;
    logic [D-1:0]       twice_dcol_reg, twice_dcol_next;
    logic [E-1:0]       error_term_reg, error_term_next;
    logic               row_major_reg, row_major_next;
    logic               busy_reg, busy_next;
    logic [COLOR_W-1:0] held_color_reg, held_color_next;

    logic [C-1:0] sr, sc, er, ec;
    logic [C:0]   drow_raw, dcol_raw, drow_mag, dcol_mag;
    logic [C-1:0] adr, adc;
    logic [D-1:0] twice_dr, twice_dc;
    logic         major_init;
    logic         done_init;
    logic [E-1:0] err_work;
    logic [C-1:0] row_step, col_step;

    assign sr = C'(item.start_row);
    assign sc = C'(item.start_col);
    assign er = C'(item.end_row);
    assign ec = C'(item.end_col);

    // Setup for a new line: signed deltas, magnitudes, doubled spans, major axis and done flag.
    assign drow_raw   = {1'b0, er} - {1'b0, sr};
    assign dcol_raw   = {1'b0, ec} - {1'b0, sc};
    assign drow_mag   = drow_raw[C] ? (~drow_raw + 1'b1) : drow_raw;
    assign dcol_mag   = dcol_raw[C] ? (~dcol_raw + 1'b1) : dcol_raw;
    assign adr        = drow_mag[C-1:0];
    assign adc        = dcol_mag[C-1:0];
    assign twice_dr   = {adr, 1'b0};
    assign twice_dc   = {adc, 1'b0};
    assign major_init = adr > adc;
    assign done_init  = major_init ? (sr == er) : (sc == ec);

    assign row_step = row_dir_neg_reg ? (row_now_reg - 1'b1) : (row_now_reg + 1'b1);
    assign col_step = col_dir_neg_reg ? (col_now_reg - 1'b1) : (col_now_reg + 1'b1);

    always_comb begin
        row_now_next     = row_now_reg;
        col_now_next     = col_now_reg;
        row_goal_next    = row_goal_reg;
        col_goal_next    = col_goal_reg;
        row_dir_neg_next = row_dir_neg_reg;
        col_dir_neg_next = col_dir_neg_reg;
        twice_drow_next  = twice_drow_reg;
        twice_dcol_next  = twice_dcol_reg;
        error_term_next  = error_term_reg;
        row_major_next   = row_major_reg;
        busy_next        = busy_reg;
        held_color_next  = held_color_reg;
        err_work         = error_term_reg;
        result           = '0;

        if (item.op == OP_START) begin
            row_now_next     = sr;
            col_now_next     = sc;
            row_goal_next    = er;
            col_goal_next    = ec;
            row_dir_neg_next = drow_raw[C];
            col_dir_neg_next = dcol_raw[C];
            twice_drow_next  = twice_dr;
            twice_dcol_next  = twice_dc;
            row_major_next   = major_init;
            held_color_next  = item.pen_color;
            if (major_init) begin
                error_term_next = E'(twice_dc) - E'(adr);
            end else begin
                error_term_next = E'(twice_dr) - E'(adc);
            end
            busy_next = !done_init;
            result.pixel_valid = 1'b1;
            result.line_done   = done_init;
        end else if (busy_reg) begin
            // A non-negative error term moves the minor axis as well.
            if (row_major_reg) begin
                if (!error_term_reg[E-1]) begin
                    col_now_next = col_step;
                    err_work     = error_term_reg - E'(twice_drow_reg);
                end
                row_now_next    = row_step;
                error_term_next = err_work + E'(twice_dcol_reg);
                busy_next       = row_step != row_goal_reg;
            end else begin
                if (!error_term_reg[E-1]) begin
                    row_now_next = row_step;
                    err_work     = error_term_reg - E'(twice_dcol_reg);
                end
                col_now_next    = col_step;
                error_term_next = err_work + E'(twice_drow_reg);
                busy_next       = col_step != col_goal_reg;
            end
            result.pixel_valid = 1'b1;
            result.line_done   = !busy_next;
        end

        if (result.pixel_valid) begin
            result.pixel_row   = PORT_COORD_W'(row_now_next);
            result.pixel_col   = PORT_COORD_W'(col_now_next);
            result.pixel_color = held_color_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_now_reg     <= '0;
            col_now_reg     <= '0;
            row_goal_reg    <= '0;
            col_goal_reg    <= '0;
            row_dir_neg_reg <= 1'b0;
            col_dir_neg_reg <= 1'b0;
            twice_drow_reg  <= '0;
            twice_dcol_reg  <= '0;
            error_term_reg  <= '0;
            row_major_reg   <= 1'b0;
            busy_reg        <= 1'b0;
            held_color_reg  <= '0;
        end else if (item_fire) begin
            row_now_reg     <= row_now_next;
            col_now_reg     <= col_now_next;
            row_goal_reg    <= row_goal_next;
            col_goal_reg    <= col_goal_next;
            row_dir_neg_reg <= row_dir_neg_next;
            col_dir_neg_reg <= col_dir_neg_next;
            twice_drow_reg  <= twice_drow_next;
            twice_dcol_reg  <= twice_dcol_next;
            error_term_reg  <= error_term_next;
            row_major_reg   <= row_major_next;
            busy_reg        <= busy_next;
            held_color_reg  <= held_color_next;
        end
    end

endmodule

// File: design/line_pixel_rasterizer_unit.sv
// Line pixel rasterizer: a start item loads a line, each step item yields its next pixel.
// Input channel s_*: tuser[0] is the op (start or step); tdata carries both endpoints
// and the pen color and is only looked at on a start.
// Result channel m_*: exactly one result item per input item, in order. tuser[0] says the
// item carries a pixel; tlast marks the pixel on the final endpoint. A step with no line
// in progress gives an item with tuser[0] low and all other fields zero.
// The accepting edge loads the input register; from there the item moves through the
// start/step logic into the output register, where it is shown.
// Throughput is one item per clock while the receiver keeps up; the next pixel depends on
// the line state alone, updated in the same cycle that its item enters the output register.
// When the receiver stalls, both registers hold and s_tready drops until the output
// register drains; nothing is lost or repeated.
// A start while a line is in progress abandons that line. Reset (aresetn low, synchronous)
// empties both registers and returns the line state to idle.
`timescale 1ns / 1ps

module line_pixel_rasterizer_unit
    import lpr_pkg::*;
#(
    parameter int COORD_BITS = 8
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // start_row[7:0], start_col[15:8], end_row[23:16], end_col[31:24], pen_color[43:32]
    input  logic [S_TDATA_W-1:0] s_tdata,
    // op[0]
    input  logic [0:0]           s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // pixel_row[7:0], pixel_col[15:8], pixel_color[27:16]
    output logic [M_TDATA_W-1:0] m_tdata,
    // pixel_valid[0]
    output logic [0:0]           m_tuser,
    // line_done
    output logic                 m_tlast
);

    logic        advance;
    logic        in_valid_reg;
    lpr_item_t   in_item_reg, in_item_next;
    logic        out_valid_reg;
    lpr_result_t out_res_reg;
    lpr_result_t core_res;

    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = advance;

    always_comb begin
        in_item_next.op        = s_tuser[0];
        in_item_next.start_row = s_tdata[7:0];
        in_item_next.start_col = s_tdata[15:8];
        in_item_next.end_row   = s_tdata[23:16];
        in_item_next.end_col   = s_tdata[31:24];
        in_item_next.pen_color = s_tdata[43:32];
    end

    lpr_core #(
        .COORD_BITS(COORD_BITS)
    ) u_core (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .item_fire(advance && in_valid_reg),
        .item     (in_item_reg),
        .result   (core_res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            in_valid_reg  <= s_tvalid;
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            in_item_reg <= in_item_next;
            out_res_reg <= core_res;
        end
    end

    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = {4'b0000, out_res_reg.pixel_color, out_res_reg.pixel_col,
                         out_res_reg.pixel_row};
    assign m_tuser[0] = out_res_reg.pixel_valid;
    assign m_tlast    = out_res_reg.line_done;

endmodule

// File: sim/lpr_checker.sv
// Checker for the line pixel rasterizer: predicts each pixel item and compares it.
`timescale 1ns / 1ps

module lpr_checker
    import lpr_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic [0:0]           s_tuser,
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [M_TDATA_W-1:0] m_tdata,
    input  logic [0:0]           m_tuser,
    input  logic                 m_tlast,
    output int                   fail_count,
    output int                   pixels_owed
);

    lpr_result_t owed_pixels[$];

    // Line state as the predictor sees it.
    logic [7:0]  cur_row, cur_col, goal_row, goal_col;
    logic        row_neg, col_neg, row_major, drawing;
    int          dbl_drow, dbl_dcol, err_acc;
    logic [11:0] pen;

    initial begin
        fail_count  = 0;
        pixels_owed = 0;
    end

    task automatic flag_error(input string msg);
        $display("checker: %s at %0t", msg, $realtime);
        fail_count++;
    endtask

    function automatic logic [7:0] nudge(input logic [7:0] v, input logic neg);
        return neg ? v - 8'd1 : v + 8'd1;
    endfunction

    function automatic lpr_result_t rasterize(input lpr_item_t it);
        lpr_result_t px;
        int          dr, dc;
        logic        done;
        px = '0;
        if (it.op == OP_START) begin
            cur_row  = it.start_row;
            cur_col  = it.start_col;
            goal_row = it.end_row;
            goal_col = it.end_col;
            pen      = it.pen_color;
            dr = int'(goal_row) - int'(cur_row);
            dc = int'(goal_col) - int'(cur_col);
            row_neg = (dr < 0);
            col_neg = (dc < 0);
            if (dr < 0) dr = -dr;
            if (dc < 0) dc = -dc;
            dbl_drow  = 2 * dr;
            dbl_dcol  = 2 * dc;
            // Ties go to the column axis.
            row_major = (dbl_drow > dbl_dcol);
            if (row_major) begin
                err_acc = dbl_dcol - dr;
                done    = (cur_row == goal_row);
            end else begin
                err_acc = dbl_drow - dc;
                done    = (cur_col == goal_col);
            end
            drawing = !done;
        end else if (drawing) begin
            if (row_major) begin
                if (err_acc >= 0) begin
                    cur_col = nudge(cur_col, col_neg);
                    err_acc -= dbl_drow;
                end
                cur_row = nudge(cur_row, row_neg);
                err_acc += dbl_dcol;
                drawing = (cur_row != goal_row);
            end else begin
                if (err_acc >= 0) begin
                    cur_row = nudge(cur_row, row_neg);
                    err_acc -= dbl_dcol;
                end
                cur_col = nudge(cur_col, col_neg);
                err_acc += dbl_drow;
                drawing = (cur_col != goal_col);
            end
            done = !drawing;
        end else begin
            // A step with no line in progress yields an empty item.
            return px;
        end
        px.pixel_valid = 1'b1;
        px.pixel_row   = cur_row;
        px.pixel_col   = cur_col;
        px.pixel_color = pen;
        px.line_done   = done;
        return px;
    endfunction

    task automatic check_pixel();
        lpr_result_t want;
        if (owed_pixels.size() == 0) begin
            flag_error("pixel item arrived with none expected");
        end else begin
            want = owed_pixels.pop_front();
            if (m_tuser[0] !== want.pixel_valid)
                flag_error($sformatf("pixel_valid got %b want %b", m_tuser[0], want.pixel_valid));
            if (m_tdata[7:0] !== want.pixel_row)
                flag_error($sformatf("pixel_row got %0d want %0d", m_tdata[7:0], want.pixel_row));
            if (m_tdata[15:8] !== want.pixel_col)
                flag_error($sformatf("pixel_col got %0d want %0d", m_tdata[15:8], want.pixel_col));
            if (m_tdata[27:16] !== want.pixel_color)
                flag_error($sformatf("pixel_color got %h want %h", m_tdata[27:16],
                                     want.pixel_color));
            if (m_tlast !== want.line_done)
                flag_error($sformatf("line_done got %b want %b", m_tlast, want.line_done));
        end
    endtask

    always @(posedge aclk) begin
        lpr_item_t it;
        if (!aresetn) begin
            cur_row   = '0;
            cur_col   = '0;
            goal_row  = '0;
            goal_col  = '0;
            row_neg   = 1'b0;
            col_neg   = 1'b0;
            row_major = 1'b0;
            drawing   = 1'b0;
            dbl_drow  = 0;
            dbl_dcol  = 0;
            err_acc   = 0;
            pen       = '0;
            owed_pixels.delete();
        end else begin
            if (s_tvalid && s_tready) begin
                it.op        = s_tuser[0];
                it.start_row = s_tdata[7:0];
                it.start_col = s_tdata[15:8];
                it.end_row   = s_tdata[23:16];
                it.end_col   = s_tdata[31:24];
                it.pen_color = s_tdata[43:32];
                owed_pixels.push_back(rasterize(it));
            end
            if (m_tvalid && m_tready)
                check_pixel();
        end
        pixels_owed = owed_pixels.size();
    end

endmodule

// File: sim/tb.sv
// Top of the line pixel rasterizer testbench: clock, reset, line stimulus and verdict.
`timescale 1ns / 1ps

module tb;
    import lpr_pkg::*;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic [0:0]           s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [0:0]           m_tuser;
    logic                 m_tlast;

    int fail_count;
    int pixels_owed;
    int items_sent;
    int pixels_taken;

    line_pixel_rasterizer_unit u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    lpr_checker u_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast),
        .fail_count  (fail_count),
        .pixels_owed (pixels_owed)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    initial begin
        #5_000_000;
        $display("tb: done, errors");
        $finish;
    end

    task automatic send_item(input logic op, input logic [7:0] sr, input logic [7:0] sc,
                             input logic [7:0] er, input logic [7:0] ec,
                             input logic [11:0] color);
        int gap;
        // Every third run of 60 items goes back to back.
        gap = ((items_sent / 60) % 3 == 0) ? 0 : $urandom_range(0, 15);
        repeat (gap) @(negedge aclk) s_tvalid <= 1'b0;
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {4'b0000, color, ec, er, sc, sr};
        do @(posedge aclk); while (!(s_tvalid && s_tready));
        items_sent++;
    endtask

    // The endpoint and color fields of a step item are ignored, so they carry noise.
    task automatic send_step();
        send_item(OP_STEP, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                  12'($urandom));
    endtask

    task automatic draw_line(input int sr, input int sc, input int er, input int ec,
                             input int color, input int steps);
        send_item(OP_START, 8'(sr), 8'(sc), 8'(er), 8'(ec), 12'(color));
        repeat (steps) send_step();
    endtask

    task automatic random_line();
        int sr, sc, er, ec, dr, dc, span, steps;
        sr = $urandom_range(0, 255);
        sc = $urandom_range(0, 255);
        if ($urandom_range(0, 99) < 12) begin
            er = $urandom_range(0, 255);
            ec = $urandom_range(0, 255);
        end else begin
            // Mostly short lines so that many of them finish.
            er = $urandom_range(sr < 15 ? 0 : sr - 15, sr > 240 ? 255 : sr + 15);
            ec = $urandom_range(sc < 15 ? 0 : sc - 15, sc > 240 ? 255 : sc + 15);
        end
        dr = (er > sr) ? er - sr : sr - er;
        dc = (ec > sc) ? ec - sc : sc - ec;
        span = (dr > dc) ? dr : dc;
        if ($urandom_range(0, 4) == 0)
            steps = $urandom_range(0, span);
        else
            steps = span + $urandom_range(0, 2);
        draw_line(sr, sc, er, ec, $urandom_range(0, 4095), steps);
    endtask

    // Result side: random stalls, bursts with none, and one long hold-off.
    initial begin
        int  wait_cycles;
        logic held_off;
        m_tready     = 1'b0;
        pixels_taken = 0;
        held_off     = 1'b0;
        @(posedge aresetn);
        forever begin
            wait_cycles = ((pixels_taken / 45) % 3 == 0) ? 0 : $urandom_range(0, 15);
            if (!held_off && pixels_taken >= 250) begin
                wait_cycles = 300;
                held_off    = 1'b1;
            end
            repeat (wait_cycles) @(negedge aclk) m_tready <= 1'b0;
            @(negedge aclk) m_tready <= 1'b1;
            do @(posedge aclk); while (!(m_tvalid && m_tready));
            pixels_taken++;
        end
    end

    initial begin
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tuser    = OP_START;
        aresetn    = 1'b0;
        items_sent = 0;
        repeat (12) @(posedge aclk);
        @(negedge aclk) aresetn <= 1'b1;

        // Step with nothing drawn, then a single-point line at the far corner.
        send_item(OP_STEP, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 12'hFFF);
        draw_line(255, 255, 255, 255, 12'hFFF, 1);
        // Shallow line from the origin, column axis major, run to its end.
        draw_line(0, 0, 2, 5, 12'h000, 5);
        // Equal spans fall to the column axis; abandoned midway by the next start.
        draw_line(10, 200, 14, 196, 12'h5A5, 2);
        // Steep line with both axes stepping downward.
        draw_line(255, 3, 250, 0, 12'hA5A, 5);
        // Vertical line on the last column, with one extra step after it ends.
        draw_line(0, 255, 3, 255, 12'h0F0, 4);

        while (items_sent < 850) begin
            if ($urandom_range(0, 9) == 0)
                send_step();
            else
                random_line();
        end
        @(negedge aclk) s_tvalid <= 1'b0;

        while (pixels_owed != 0) @(negedge aclk);
        repeat (10) @(negedge aclk);
        if (fail_count == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

endmodule
